// ===== src/ptt_pkg.sv =====
// Shared types, codes and constants of the periodic task timer table.
package ptt_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int DELAY_BITS_DEF = 16;

    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int TIME_W   = 27;
    localparam int MASK_W   = 16;

    localparam int unsigned MS_PER_SECOND = 1000;
    localparam logic [TIME_W-1:0] MS_PER_DAY = TIME_W'(24 * 60 * 60 * MS_PER_SECOND);

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_ADD      = 3'd1,
        KIND_REMOVE   = 3'd2,
        KIND_DISPATCH = 3'd3,
        KIND_SET_TIME = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECTED = 2'd1,
        ST_NONE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_DISP,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [FIELD_W-1:0]  period;
        logic [FIELD_W-1:0]  first_delay;
        logic [TIME_W-1:0]   time_value;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   chosen_slot;
        logic [MASK_W-1:0]   pending_mask;
        logic [TIME_W-1:0]   time_now;
    } t_result;

    typedef struct packed {
        logic                tick;
        logic                load;
        logic [TIME_W-1:0]   value;
    } t_tod_cmd;

endpackage

// ===== src/ptt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ptt_tod.sv =====
// Millisecond time-of-day counter with tick advance, day wrap and load.
module ptt_tod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptt_pkg::t_tod_cmd        i_cmd,
    output logic [ptt_pkg::TIME_W-1:0] o_ms
);

    logic [ptt_pkg::TIME_W-1:0] r_ms;
    logic [ptt_pkg::TIME_W-1:0] n_ms;

    always_comb begin
        n_ms = r_ms;
        if (i_cmd.load) begin
            n_ms = (i_cmd.value >= ptt_pkg::MS_PER_DAY) ? '0 : i_cmd.value;
        end else if (i_cmd.tick) begin
            n_ms = (r_ms == ptt_pkg::MS_PER_DAY - 1'b1) ? '0 : r_ms + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
        end else begin
            r_ms <= n_ms;
        end
    end

    assign o_ms = r_ms;

    a_ms_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_ms < ptt_pkg::MS_PER_DAY))
        else $error("time of day beyond last millisecond");

endmodule

// ===== src/ptt_engine.sv =====
// Slot sequencer: flag vectors, period/count memory walk, dispatch scan and time keeping.
module ptt_engine #(
    parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF,
    parameter int DELAY_BITS = ptt_pkg::DELAY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ptt_pkg::t_item    i_item,
    output logic              o_ready,
    input  logic              i_res_free,
    output logic              o_res_valid,
    output ptt_pkg::t_result  o_res
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int RW = 2 * DELAY_BITS;
    localparam logic [CW-1:0] CNT_END  = CW'(SLOT_COUNT);
    localparam logic [CW-1:0] CNT_LAST = CW'(SLOT_COUNT - 1);
    localparam logic [SW-1:0] IDX_LAST = SW'(SLOT_COUNT - 1);

    ptt_pkg::t_state r_state;
    ptt_pkg::t_state n_state;

    logic [SLOT_COUNT-1:0]       r_active, n_active;
    logic [SLOT_COUNT-1:0]       r_pending, n_pending;
    logic [SW-1:0]               r_ptr, n_ptr;
    logic [SW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_wb_valid, n_wb_valid;
    logic [SW-1:0]               r_wb_idx, n_wb_idx;
    ptt_pkg::t_status            r_status, n_status;
    logic [ptt_pkg::SLOT_W-1:0]  r_chosen, n_chosen;

    logic                        wr_en;
    logic [SW-1:0]               wr_addr;
    logic [RW-1:0]               wr_data;
    logic [SW-1:0]               rd_addr;
    logic [RW-1:0]               rd_data;
    logic [DELAY_BITS-1:0]       rd_period;
    logic [DELAY_BITS-1:0]       rd_count;

    ptt_pkg::t_tod_cmd           tod_cmd;
    logic [ptt_pkg::TIME_W-1:0]  tod_ms;

    logic                        slot_ok;
    logic [SW-1:0]               slot_idx;
    logic                        hit;
    logic [SW-1:0]               idx_next;

    assign rd_period = rd_data[RW-1:DELAY_BITS];
    assign rd_count  = rd_data[DELAY_BITS-1:0];
    assign slot_ok   = (32'(i_item.slot) < SLOT_COUNT);
    assign slot_idx  = SW'(i_item.slot);
    assign hit       = r_active[r_idx] && r_pending[r_idx];
    assign idx_next  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    ptt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ptt_tod u_tod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tod_cmd),
        .o_ms    (tod_ms)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.kind)
                        ptt_pkg::KIND_TICK:     n_state = ptt_pkg::S_TICK;
                        ptt_pkg::KIND_DISPATCH: n_state = ptt_pkg::S_SCAN;
                        default:                n_state = ptt_pkg::S_FINISH;
                    endcase
                end
            end
            ptt_pkg::S_TICK: begin
                if (r_cnt == CNT_END) begin
                    n_state = ptt_pkg::S_FINISH;
                end
            end
            ptt_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = ptt_pkg::S_DISP;
                end else if (r_cnt == CNT_LAST) begin
                    n_state = ptt_pkg::S_FINISH;
                end
            end
            ptt_pkg::S_DISP: n_state = ptt_pkg::S_FINISH;
            ptt_pkg::S_FINISH: begin
                if (i_res_free) begin
                    n_state = ptt_pkg::S_IDLE;
                end
            end
            default: n_state = ptt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_pending   = r_pending;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_wb_valid  = 1'b0;
        n_wb_idx    = r_wb_idx;
        n_status    = r_status;
        n_chosen    = r_chosen;
        wr_en       = 1'b0;
        wr_addr     = r_wb_idx;
        wr_data     = {rd_period, rd_period};
        rd_addr     = r_idx;
        tod_cmd     = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ptt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_status = ptt_pkg::ST_DONE;
                    n_chosen = '0;
                    n_cnt    = '0;
                    unique case (i_item.kind)
                        ptt_pkg::KIND_TICK: begin
                            tod_cmd.tick = 1'b1;
                        end
                        ptt_pkg::KIND_ADD: begin
                            if (!slot_ok || r_active[slot_idx]) begin
                                n_status = ptt_pkg::ST_REJECTED;
                            end else begin
                                wr_en               = 1'b1;
                                wr_addr             = slot_idx;
                                wr_data             = {DELAY_BITS'(i_item.period),
                                                       DELAY_BITS'(i_item.first_delay)};
                                n_active[slot_idx]  = 1'b1;
                                n_pending[slot_idx] = 1'b0;
                            end
                        end
                        ptt_pkg::KIND_REMOVE: begin
                            if (!slot_ok || !r_active[slot_idx]) begin
                                n_status = ptt_pkg::ST_REJECTED;
                            end else begin
                                n_active[slot_idx]  = 1'b0;
                                n_pending[slot_idx] = 1'b0;
                            end
                        end
                        ptt_pkg::KIND_DISPATCH: begin
                            n_idx = r_ptr;
                        end
                        ptt_pkg::KIND_SET_TIME: begin
                            tod_cmd.load  = 1'b1;
                            tod_cmd.value = i_item.time_value;
                        end
                        default: ;
                    endcase
                end
            end
            ptt_pkg::S_TICK: begin
                rd_addr = r_cnt[SW-1:0];
                if (r_cnt != CNT_END) begin
                    n_wb_valid = 1'b1;
                    n_wb_idx   = r_cnt[SW-1:0];
                    n_cnt      = r_cnt + 1'b1;
                end
                if (r_wb_valid && r_active[r_wb_idx] && rd_count != '0) begin
                    wr_en = 1'b1;
                    if (rd_count == DELAY_BITS'(1)) begin
                        wr_data             = {rd_period, rd_period};
                        n_pending[r_wb_idx] = 1'b1;
                    end else begin
                        wr_data = {rd_period, DELAY_BITS'(rd_count - 1'b1)};
                    end
                end
            end
            ptt_pkg::S_SCAN: begin
                if (!hit) begin
                    if (r_cnt == CNT_LAST) begin
                        n_status = ptt_pkg::ST_NONE;
                    end else begin
                        n_idx = idx_next;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ptt_pkg::S_DISP: begin
                n_pending[r_idx] = 1'b0;
                if (rd_period == '0) begin
                    n_active[r_idx] = 1'b0;
                end
                n_ptr    = idx_next;
                n_chosen = ptt_pkg::SLOT_W'(r_idx);
            end
            ptt_pkg::S_FINISH: begin
                o_res_valid = i_res_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.status       = r_status;
        o_res.chosen_slot  = r_chosen;
        o_res.pending_mask = ptt_pkg::MASK_W'(r_pending);
        o_res.time_now     = tod_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptt_pkg::S_IDLE;
            r_active   <= '0;
            r_pending  <= '0;
            r_ptr      <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_pending  <= n_pending;
            r_ptr      <= n_ptr;
            r_wb_valid <= n_wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_wb_idx <= n_wb_idx;
        r_status <= n_status;
        r_chosen <= n_chosen;
    end

    a_tick_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptt_pkg::S_TICK && wr_en) |-> (wr_addr != rd_addr))
        else $error("tick write-back hits the entry being read");

    a_pending_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_pending & ~r_active) == '0))
        else $error("pending flag set on an inactive slot");

    a_dispatch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptt_pkg::S_DISP) |=> !r_pending[$past(r_idx)])
        else $error("dispatched slot still pending");

endmodule

// ===== src/periodic_task_timer_table_top.sv =====
// Top level of the periodic task timer table with stream ports and output register.
// A tick request walks the period/count memory, one slot a cycle on its single read port,
// and a dispatch request scans the flag vectors round-robin, one slot a cycle, up to the
// first active pending slot; add, remove, set time and unknown kinds go straight from
// idle to the finish state. A finished result sits in an output register, so the next
// request is accepted while it waits to be taken. The period/count memory needs no
// clearing after reset: an entry is read only for an active slot, which an add has
// always written.
module periodic_task_timer_table_top #(
    parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF,
    parameter int DELAY_BITS = ptt_pkg::DELAY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // slot[3:0], period[19:4], first_delay[35:20], time_value[62:36]
    input  logic [2:0]  s_tuser,  // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // chosen_slot[3:0], pending_mask[19:4], time_now[46:20]
    output logic [1:0]  m_tuser   // status[1:0]
);

    ptt_pkg::t_item   item;
    ptt_pkg::t_result res;
    ptt_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic             res_valid;
    logic             res_free;
    logic             start;

    always_comb begin
        item.kind        = ptt_pkg::t_kind'(s_tuser);
        item.slot        = s_tdata[3:0];
        item.period      = s_tdata[19:4];
        item.first_delay = s_tdata[35:20];
        item.time_value  = s_tdata[62:36];
    end

    assign start    = s_tvalid && s_tready;
    assign res_free = !r_out_valid || m_tready;

    ptt_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .DELAY_BITS (DELAY_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .o_ready     (s_tready),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {1'b0, r_out.time_now, r_out.pending_mask, r_out.chosen_slot};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || m_tready))
        else $error("result overwrites one not yet taken");

endmodule
